FILE: hdl/qil_pkg.sv
// Shared types, codes and constants for the qualified identifier lexer.
`timescale 1ns / 1ps

package qil_pkg;

  localparam int MAX_PARTS_DEF   = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam logic [7:0] MAX_PART_BYTES_RST = 8'd128;

  localparam logic [CFG_ADDR_W-3:0] REG_MAX_PART_BYTES = '0;

  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_UNDER   = 8'h5f;
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DEL     = 8'h7f;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_UNQ,
    MODE_QOPEN,
    MODE_QQUOTE
  } lex_mode_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY_NAME   = 4'd1,
    ST_EMPTY_PART   = 4'd2,
    ST_EMPTY_QUOTED = 4'd3,
    ST_CONTROL      = 4'd4,
    ST_UNTERMINATED = 4'd5,
    ST_BAD_START    = 4'd6,
    ST_TOO_LONG     = 4'd7,
    ST_TOO_MANY     = 4'd8,
    ST_BAD_SEP      = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
    logic       empty_name;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] part_index;
    logic       name_done;
    status_t    status;
  } out_t;

  // Lexer state apart from the part count, whose width follows MAX_PARTS
  typedef struct packed {
    lex_mode_t  mode;
    logic [7:0] part_length;
    logic       quoted_seen;
    logic       length_over;
    status_t    error;
  } lex_state_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) ? b - CASE_OFFSET : b;
  endfunction

endpackage

FILE: hdl/qil_step.sv
// Per-byte lexer step: next state and the result for one transaction.
`timescale 1ns / 1ps

module qil_step #(
  parameter int MAX_PARTS = qil_pkg::MAX_PARTS_DEF,
  parameter int CNT_W     = $clog2(MAX_PARTS + 2)
) (
  input  qil_pkg::in_t       item,
  input  qil_pkg::lex_state_t cur,
  input  logic [CNT_W-1:0]   cnt,
  input  logic [7:0]         max_part_bytes,
  output qil_pkg::lex_state_t nxt,
  output logic [CNT_W-1:0]   cnt_nxt,
  output qil_pkg::out_t      result
);

  localparam logic [CNT_W-1:0] PARTS_LIM = CNT_W'(MAX_PARTS);

  logic [7:0]       b;
  logic             emit;
  logic [7:0]       ob;
  logic             cb_fits;
  logic [7:0]       cb_len;
  logic             start_ok;
  logic             part_ok;
  logic [CNT_W-1:0] cnt_inc;

  assign b        = item.name_byte;
  assign cb_fits  = cur.part_length < max_part_bytes;
  assign cb_len   = cb_fits ? cur.part_length + 8'd1 : cur.part_length;
  assign start_ok = qil_pkg::is_alpha(b) || b == qil_pkg::CHAR_UNDER;
  assign part_ok  = start_ok || qil_pkg::is_digit(b) || b == qil_pkg::CHAR_DOLLAR ||
                    b == qil_pkg::CHAR_HASH;
  assign cnt_inc  = cnt + CNT_W'(1);

  always_comb begin
    nxt     = cur;
    cnt_nxt = cnt;
    emit    = 1'b0;
    ob      = '0;

    if (cur.error == qil_pkg::ST_OK) begin
      unique case (cur.mode)
        qil_pkg::MODE_START: begin
          if (b == qil_pkg::CHAR_QUOTE) begin
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            nxt.mode        = qil_pkg::MODE_QOPEN;
            nxt.quoted_seen = 1'b0;
          end else if (start_ok) begin
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            nxt.mode        = qil_pkg::MODE_UNQ;
            emit            = 1'b1;
            ob              = qil_pkg::to_upper(b);
          end else begin
            nxt.error = qil_pkg::ST_BAD_START;
          end
        end
        qil_pkg::MODE_QOPEN: begin
          if (b == qil_pkg::CHAR_QUOTE) begin
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            nxt.mode        = qil_pkg::MODE_QQUOTE;
          end else if (b < qil_pkg::CHAR_SPACE || b == qil_pkg::CHAR_DEL) begin
            nxt.error = qil_pkg::ST_CONTROL;
          end else begin
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            nxt.quoted_seen = 1'b1;
            emit            = 1'b1;
            ob              = b;
          end
        end
        qil_pkg::MODE_UNQ, qil_pkg::MODE_QQUOTE: begin
          if (cur.mode == qil_pkg::MODE_UNQ && part_ok) begin
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            emit            = 1'b1;
            ob              = qil_pkg::to_upper(b);
          end else if (cur.mode == qil_pkg::MODE_QQUOTE && b == qil_pkg::CHAR_QUOTE) begin
            // doubled quote: one literal quote, back inside the part
            nxt.part_length = cb_len;
            nxt.length_over = cur.length_over | ~cb_fits;
            nxt.quoted_seen = 1'b1;
            nxt.mode        = qil_pkg::MODE_QOPEN;
            emit            = 1'b1;
            ob              = qil_pkg::CHAR_QUOTE;
          end else if (cur.mode == qil_pkg::MODE_QQUOTE && !cur.quoted_seen) begin
            nxt.error = qil_pkg::ST_EMPTY_QUOTED;
          end else begin
            // part ends here; this byte must be the separator
            if (cur.length_over) begin
              nxt.error = qil_pkg::ST_TOO_LONG;
            end else begin
              cnt_nxt = cnt_inc;
              if (cnt_inc > PARTS_LIM) begin
                nxt.error = qil_pkg::ST_TOO_MANY;
              end
            end
            if (nxt.error == qil_pkg::ST_OK) begin
              if (b == qil_pkg::CHAR_DOT) begin
                nxt.mode        = qil_pkg::MODE_START;
                nxt.part_length = '0;
                nxt.quoted_seen = 1'b0;
                nxt.length_over = 1'b0;
              end else begin
                nxt.error = qil_pkg::ST_BAD_SEP;
              end
            end
          end
        end
        default: nxt.error = cur.error;
      endcase
    end

    // end-of-name checks on the state left by this byte
    if (item.last_byte && nxt.error == qil_pkg::ST_OK) begin
      unique case (nxt.mode)
        qil_pkg::MODE_START: nxt.error = qil_pkg::ST_EMPTY_PART;
        qil_pkg::MODE_QOPEN: nxt.error = qil_pkg::ST_UNTERMINATED;
        qil_pkg::MODE_UNQ, qil_pkg::MODE_QQUOTE: begin
          if (nxt.mode == qil_pkg::MODE_QQUOTE && !nxt.quoted_seen) begin
            nxt.error = qil_pkg::ST_EMPTY_QUOTED;
          end else if (nxt.length_over) begin
            nxt.error = qil_pkg::ST_TOO_LONG;
          end else if (cnt_nxt + CNT_W'(1) > PARTS_LIM) begin
            nxt.error = qil_pkg::ST_TOO_MANY;
          end
        end
        default: nxt.error = nxt.error;
      endcase
    end

    result.out_valid  = emit && (cnt < PARTS_LIM);
    result.out_byte   = result.out_valid ? ob : 8'd0;
    result.part_index = result.out_valid ? cnt[1:0] : 2'd0;
    result.name_done  = item.last_byte;
    result.status     = nxt.error;

    if (item.empty_name) begin
      result.out_valid  = 1'b0;
      result.out_byte   = 8'd0;
      result.part_index = 2'd0;
      result.name_done  = 1'b1;
      result.status     = qil_pkg::ST_EMPTY_NAME;
    end

    // a finished name returns the lexer to its idle state
    if (item.empty_name || item.last_byte) begin
      nxt.mode        = qil_pkg::MODE_START;
      nxt.part_length = '0;
      nxt.quoted_seen = 1'b0;
      nxt.length_over = 1'b0;
      nxt.error       = qil_pkg::ST_OK;
      cnt_nxt         = '0;
    end
  end

endmodule

FILE: hdl/qualified_identifier_lexer.sv
// Top level of the qualified identifier lexer: channels, registers, config port.
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_stall    qil_pkg::in_t  (one name byte)
//  out_      output     out_valid/out_stall  qil_pkg::out_t (one result)
//  cfg_      input      APB write/read       max_part_bytes at byte address 0
//
// One transaction in, one result out, one transaction per cycle sustained while out_stall is low.
// The path is an input register, then the lexer step into the result
// register. The per-byte mode update is the only loop.
// Reset (synchronous, rst_n low) empties both stages and clears the lexer state;
// max_part_bytes returns to 128. A stalled result holds the output register and
// the input register holds behind it; in_stall rises only when both are full.
`timescale 1ns / 1ps

module qualified_identifier_lexer #(
  parameter int MAX_PARTS = qil_pkg::MAX_PARTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  qil_pkg::in_t                   in_data,

  output logic                           out_valid,
  input  logic                           out_stall,
  output qil_pkg::out_t                  out_data,

  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [qil_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qil_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qil_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  // part count must reach MAX_PARTS + 1 to flag too many parts
  localparam int CNT_W = $clog2(MAX_PARTS + 2);

  logic                s1_valid_r;
  qil_pkg::in_t        s1_data_r;
  logic                out_valid_r;
  qil_pkg::out_t       out_data_r;

  qil_pkg::lex_state_t lex_r;
  qil_pkg::lex_state_t lex_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  qil_pkg::out_t       result;

  logic [7:0]          max_part_bytes_r;
  logic                reg_sel;
  logic                advance;

  // ---- configuration port: single register, writes land in the access phase
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[qil_pkg::CFG_ADDR_W-1:2] == qil_pkg::REG_MAX_PART_BYTES;
  assign cfg_prdata = reg_sel ? {{(qil_pkg::CFG_DATA_W-8){1'b0}}, max_part_bytes_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_part_bytes_r <= qil_pkg::MAX_PART_BYTES_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      max_part_bytes_r <= cfg_pwdata[7:0];
    end
  end

  // ---- handshake: advance the input stage when the result register frees up
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  qil_step #(
    .MAX_PARTS (MAX_PARTS),
    .CNT_W     (CNT_W)
  ) u_step (
    .item           (s1_data_r),
    .cur            (lex_r),
    .cnt            (cnt_r),
    .max_part_bytes (max_part_bytes_r),
    .nxt            (lex_nxt),
    .cnt_nxt        (cnt_nxt),
    .result         (result)
  );

  // lexer state moves only when a transaction leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r.mode        <= qil_pkg::MODE_START;
      lex_r.part_length <= '0;
      lex_r.quoted_seen <= 1'b0;
      lex_r.length_over <= 1'b0;
      lex_r.error       <= qil_pkg::ST_OK;
      cnt_r             <= '0;
      out_valid_r       <= 1'b0;
    end else if (advance) begin
      lex_r       <= lex_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // result taken, nothing new behind it: drop valid
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule
